[rtl/hex_record_data_extractor_assert.svh]
// Assertion macros for the hex record data extractor.
`ifndef HEX_RECORD_DATA_EXTRACTOR_ASSERT_SVH
`define HEX_RECORD_DATA_EXTRACTOR_ASSERT_SVH

`ifndef SYNTHESIS
// Concurrent check, disabled while in reset.
`define HRDE_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
		else $error("hrde assertion failed");
// Antecedent in one cycle, consequent in the next.
`define HRDE_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("hrde assertion failed");
`else
`define HRDE_ASSERT(lbl, clk, rstn, prop)
`define HRDE_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

[rtl/hrde_pkg.sv]
// Types, constants and the digit decoder for the hex record data extractor.
package hrde_pkg;

	localparam logic [7:0] CHAR_COLON  = 8'h3A;
	localparam logic [7:0] CHAR_ZERO   = 8'h30;
	localparam logic [7:0] CHAR_NINE   = 8'h39;
	localparam logic [7:0] CHAR_UP_A   = 8'h41;
	localparam logic [7:0] CHAR_UP_F   = 8'h46;
	localparam logic [7:0] CHAR_LOW_A  = 8'h61;
	localparam logic [7:0] CHAR_LOW_F  = 8'h66;
	localparam logic [7:0] CASE_MASK   = 8'h5F;
	localparam logic [7:0] DIGIT_TEN   = 8'd10;
	localparam logic [7:0] FULL_RECORD = 8'h10;
	localparam logic [7:0] SKIP_LENGTH = 8'd2;

	typedef enum logic [3:0] {
		PH_WAIT,
		PH_LEN,
		PH_ADDR,
		PH_TYPE,
		PH_DATA,
		PH_CHK
	} phase_t;

	// Case-insensitive hex digit; anything else decodes as zero.
	function automatic logic [3:0] hex_nibble(input logic [7:0] c);
		logic [7:0] v;
		logic [7:0] d;
		v = c;
		d = 8'd0;
		if (v >= CHAR_LOW_A && v <= CHAR_LOW_F)
			v = v & CASE_MASK;
		if (v >= CHAR_UP_A && v <= CHAR_UP_F)
			d = v - CHAR_UP_A + DIGIT_TEN;
		else if (v >= CHAR_ZERO && v <= CHAR_NINE)
			d = v - CHAR_ZERO;
		return d[3:0];
	endfunction

endpackage

[rtl/hrde_if.sv]
// Valid/ready channel interfaces: character stream in, image bytes out.
interface hrde_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;

	modport source (output valid, output ch, input ready);
	modport sink   (input valid, input ch, output ready);
endinterface

interface hrde_byte_if;
	logic        valid;
	logic        ready;
	logic [7:0]  data_byte;
	logic        data_valid;
	logic        image_end;
	logic [15:0] flash_base;

	modport source (output valid, output data_byte, output data_valid,
		output image_end, output flash_base, input ready);
	modport sink   (input valid, input data_byte, input data_valid,
		input image_end, input flash_base, output ready);
endinterface

[rtl/hex_record_data_extractor.sv]
// Hex record data extractor: parses an ASCII hex record stream into image bytes.
//
//   channel  direction  payload                                           per beat
//   chars    sink       ch[7:0]                                           one character
//   image    source     data_byte, data_valid, image_end, flash_base     zero or one result
//
// One character per cycle while the image channel is not stalled; a result is offered
// after its character passes the input register, then the result register.
// The parse state updates when a character leaves the input register.
// A stalled image channel holds the result register; the input register keeps
// taking a new character in the cycle that the pending result is taken.
// Reset clears the parser to wait for the first record start.
`include "hex_record_data_extractor_assert.svh"

module hex_record_data_extractor (
	input  logic        clk,
	input  logic        arst_n,
	hrde_char_if.sink   chars,
	hrde_byte_if.source image
);
	import hrde_pkg::*;

	logic [7:0]  ch_s1;
	logic        valid_s1;

	phase_t      phase_q, phase_d;
	logic [3:0]  high_nibble_q, high_nibble_d;
	logic        toggle_q, toggle_d;
	logic [7:0]  rec_len_q, rec_len_d;
	logic [7:0]  bytes_seen_q, bytes_seen_d;
	logic        first_q, first_d;
	logic [15:0] base_q, base_d;
	logic        finished_q, finished_d;

	logic        out_valid_q;
	logic [7:0]  data_byte_q;
	logic        data_valid_q;
	logic        image_end_q;
	logic [15:0] flash_base_q;

	logic        advance;
	logic [3:0]  nib;
	logic [7:0]  cur_byte;
	logic [7:0]  seen_inc;
	logic [8:0]  seen_wide;
	logic        is_colon;
	logic        is_low_digit;
	logic        last_short;

	logic        emit;
	logic [7:0]  emit_byte;
	logic        emit_dvalid;
	logic        emit_end;

	assign advance      = valid_s1 && (!out_valid_q || image.ready);
	assign chars.ready  = !valid_s1 || advance;

	assign nib          = hex_nibble(ch_s1);
	assign cur_byte     = {high_nibble_q, nib};
	assign seen_inc     = bytes_seen_q + 8'd1;
	assign seen_wide    = {1'b0, bytes_seen_q} + 9'd1;
	assign is_colon     = (ch_s1 == CHAR_COLON);
	// second digit of a byte inside a record
	assign is_low_digit = !finished_q && !is_colon && phase_q != PH_WAIT && toggle_q;
	assign last_short   = rec_len_q < FULL_RECORD && seen_wide == {1'b0, rec_len_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.valid && chars.ready)
			ch_s1 <= chars.ch;
	end

	// next parse state
	always_comb begin
		phase_d       = phase_q;
		high_nibble_d = high_nibble_q;
		toggle_d      = toggle_q;
		rec_len_d     = rec_len_q;
		bytes_seen_d  = bytes_seen_q;
		first_d       = first_q;
		base_d        = base_q;
		finished_d    = finished_q;
		if (!finished_q) begin
			if (is_colon) begin
				phase_d      = PH_LEN;
				toggle_d     = 1'b0;
				bytes_seen_d = 8'd0;
			end else if (phase_q != PH_WAIT) begin
				if (!toggle_q) begin
					high_nibble_d = nib;
					toggle_d      = 1'b1;
				end else begin
					toggle_d = 1'b0;
					case (phase_q)
						PH_LEN: begin
							rec_len_d    = cur_byte;
							bytes_seen_d = 8'd0;
							phase_d      = PH_ADDR;
						end
						PH_ADDR: begin
							if (seen_inc >= 8'd2) begin
								bytes_seen_d = 8'd0;
								phase_d      = PH_TYPE;
							end else begin
								bytes_seen_d = seen_inc;
							end
						end
						PH_TYPE: begin
							bytes_seen_d = 8'd0;
							if (rec_len_q == 8'd0) begin
								phase_d = PH_CHK;
								if (first_q)
									first_d = 1'b0;
								else
									finished_d = 1'b1;
							end else begin
								phase_d = PH_DATA;
							end
						end
						PH_DATA: begin
							if (first_q) begin
								if (bytes_seen_q == 8'd0)
									base_d[15:8] = cur_byte;
								else if (bytes_seen_q == 8'd1)
									base_d[7:0] = cur_byte;
							end else if (rec_len_q != SKIP_LENGTH && last_short) begin
								finished_d = 1'b1;
							end
							bytes_seen_d = seen_inc;
							if (seen_inc >= rec_len_q) begin
								phase_d = PH_CHK;
								first_d = 1'b0;
							end
						end
						PH_CHK: begin
							phase_d = PH_WAIT;
						end
						default: begin
							phase_d = PH_WAIT;
						end
					endcase
				end
			end
		end
	end

	// result of the current character
	always_comb begin
		emit        = 1'b0;
		emit_byte   = 8'd0;
		emit_dvalid = 1'b0;
		emit_end    = 1'b0;
		if (is_low_digit) begin
			case (phase_q)
				PH_TYPE: begin
					if (rec_len_q == 8'd0 && !first_q) begin
						emit     = 1'b1;
						emit_end = 1'b1;
					end
				end
				PH_DATA: begin
					if (!first_q && rec_len_q != SKIP_LENGTH) begin
						emit        = 1'b1;
						emit_byte   = cur_byte;
						emit_dvalid = 1'b1;
						emit_end    = last_short;
					end
				end
				default: begin
					emit = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_WAIT;
			high_nibble_q <= 4'd0;
			toggle_q      <= 1'b0;
			rec_len_q     <= 8'd0;
			bytes_seen_q  <= 8'd0;
			first_q       <= 1'b1;
			base_q        <= 16'd0;
			finished_q    <= 1'b0;
		end else if (advance) begin
			phase_q       <= phase_d;
			high_nibble_q <= high_nibble_d;
			toggle_q      <= toggle_d;
			rec_len_q     <= rec_len_d;
			bytes_seen_q  <= bytes_seen_d;
			first_q       <= first_d;
			base_q        <= base_d;
			finished_q    <= finished_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= emit;
		end else if (image.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			data_byte_q  <= emit_byte;
			data_valid_q <= emit_dvalid;
			image_end_q  <= emit_end;
			flash_base_q <= base_q;
		end
	end

	assign image.valid      = out_valid_q;
	assign image.data_byte  = data_byte_q;
	assign image.data_valid = data_valid_q;
	assign image.image_end  = image_end_q;
	assign image.flash_base = flash_base_q;

	`HRDE_ASSERT_NEXT(a_nothing_after_end, clk, arst_n, out_valid_q && image_end_q && image.ready, !out_valid_q)
	`HRDE_ASSERT(a_end_sets_finished, clk, arst_n, !(out_valid_q && image_end_q) || finished_q)
	`HRDE_ASSERT(a_empty_result_is_end, clk, arst_n, !(out_valid_q && !data_valid_q) || (image_end_q && data_byte_q == 8'd0))
	`HRDE_ASSERT(a_wait_expects_high_digit, clk, arst_n, phase_q != PH_WAIT || !toggle_q)
	`HRDE_ASSERT_NEXT(a_base_fixed_after_first, clk, arst_n, !first_q, $stable(base_q))

endmodule

[test/hrde_image_monitor.sv]
`timescale 1ns / 1ps
// Monitor for the hex record data extractor: predicts image beats from accepted characters and checks them.
module hrde_image_monitor (
	input  logic  clk,
	input  logic  arst_n,
	hrde_char_if  chars,
	hrde_byte_if  image,
	output int    fail_count,
	output int    pending,
	output int    bytes_checked
);
	import hrde_pkg::*;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic        data_valid;
		logic        image_end;
		logic [15:0] flash_base;
	} image_beat_t;

	image_beat_t expected_q[$];

	phase_t      phase;
	logic [3:0]  upper_digit;
	logic        low_digit_next;
	logic [7:0]  rec_len;
	logic [7:0]  byte_idx;
	logic        base_pending;
	logic [15:0] base_addr;
	logic        done;

	function automatic logic [3:0] digit_of(input logic [7:0] c);
		if (c >= CHAR_ZERO && c <= CHAR_NINE)
			return c[3:0];
		// 'A'..'F' and 'a'..'f' share the low nibble 1..6
		if ((c >= CHAR_UP_A && c <= CHAR_UP_F) || (c >= CHAR_LOW_A && c <= CHAR_LOW_F))
			return c[3:0] + 4'd9;
		return 4'd0;
	endfunction

	function automatic void track_char(input logic [7:0] c);
		logic [7:0]  value;
		image_beat_t beat;
		bit          emit;
		emit = 1'b0;
		beat = '0;
		if (done)
			return;
		if (c == CHAR_COLON) begin
			phase = PH_LEN;
			low_digit_next = 1'b0;
			byte_idx = 8'd0;
			return;
		end
		if (phase == PH_WAIT)
			return;
		if (!low_digit_next) begin
			upper_digit = digit_of(c);
			low_digit_next = 1'b1;
			return;
		end
		low_digit_next = 1'b0;
		value = {upper_digit, digit_of(c)};
		case (phase)
			PH_LEN: begin
				rec_len = value;
				byte_idx = 8'd0;
				phase = PH_ADDR;
			end
			PH_ADDR: begin
				byte_idx++;
				if (byte_idx >= 8'd2) begin
					byte_idx = 8'd0;
					phase = PH_TYPE;
				end
			end
			PH_TYPE: begin
				byte_idx = 8'd0;
				if (rec_len == 8'd0) begin
					phase = PH_CHK;
					if (base_pending)
						base_pending = 1'b0;
					else begin
						emit = 1'b1;
						beat.image_end = 1'b1;
						done = 1'b1;
					end
				end else
					phase = PH_DATA;
			end
			PH_DATA: begin
				if (base_pending) begin
					if (byte_idx == 8'd0)
						base_addr[15:8] = value;
					else if (byte_idx == 8'd1)
						base_addr[7:0] = value;
				end else if (rec_len != SKIP_LENGTH) begin
					emit = 1'b1;
					beat.data_byte = value;
					beat.data_valid = 1'b1;
					if (rec_len < FULL_RECORD && {1'b0, byte_idx} + 9'd1 == {1'b0, rec_len}) begin
						beat.image_end = 1'b1;
						done = 1'b1;
					end
				end
				byte_idx++;
				if (byte_idx >= rec_len) begin
					phase = PH_CHK;
					base_pending = 1'b0;
				end
			end
			default: phase = PH_WAIT;
		endcase
		if (emit) begin
			beat.flash_base = base_addr;
			expected_q.push_back(beat);
		end
	endfunction

	function automatic void compare_field(input string name, input logic [15:0] want,
		input logic [15:0] got);
		if (got !== want) begin
			fail_count++;
			$display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
		end
	endfunction

	function automatic void check_beat();
		image_beat_t seen;
		image_beat_t want;
		seen = {image.data_byte, image.data_valid, image.image_end, image.flash_base};
		if (expected_q.size() == 0) begin
			fail_count++;
			$display("%0t: unexpected image beat: expected none, got %h", $time, seen);
			return;
		end
		want = expected_q.pop_front();
		bytes_checked++;
		compare_field("data_byte", 16'(want.data_byte), 16'(seen.data_byte));
		compare_field("data_valid", 16'(want.data_valid), 16'(seen.data_valid));
		compare_field("image_end", 16'(want.image_end), 16'(seen.image_end));
		compare_field("flash_base", want.flash_base, seen.flash_base);
	endfunction

	// Output side first, so a beat arriving with an empty queue is never masked
	// by an expectation created at the same edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase = PH_WAIT;
			upper_digit = 4'd0;
			low_digit_next = 1'b0;
			rec_len = 8'd0;
			byte_idx = 8'd0;
			base_pending = 1'b1;
			base_addr = 16'd0;
			done = 1'b0;
			expected_q.delete();
			fail_count = 0;
			bytes_checked = 0;
		end else begin
			if (image.valid && image.ready)
				check_beat();
			if (chars.valid && chars.ready)
				track_char(chars.ch);
		end
		pending = expected_q.size();
	end

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps
// Testbench top for the hex record data extractor: clock, reset, record stimulus and verdict.
module testbench;
	import hrde_pkg::*;

	localparam int CHAR_TARGET = 1100;
	localparam int CALM_AFTER  = 880;
	localparam int CYCLE_LIMIT = 100000;
	localparam int DRAIN_LIMIT = 2000;
	localparam int HOLD_START  = 300;
	localparam int HOLD_CYCLES = 120;
	// a long record takes up to about 520 characters
	localparam int LONG_ROOM   = 600;

	logic clk = 1'b0;
	logic arst_n;

	hrde_char_if chars ();
	hrde_byte_if image ();

	int fail_count;
	int pending;
	int bytes_checked;
	int chars_sent;
	int records_sent;
	int cycle_count = 0;
	int first_len;
	int end_len;
	bit calm;

	logic [7:0] rec_q[$];

	hex_record_data_extractor dut (
		.clk    (clk),
		.arst_n (arst_n),
		.chars  (chars),
		.image  (image)
	);

	hrde_image_monitor image_mon (
		.clk           (clk),
		.arst_n        (arst_n),
		.chars         (chars),
		.image         (image),
		.fail_count    (fail_count),
		.pending       (pending),
		.bytes_checked (bytes_checked)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("hex_record_data_extractor verification failed");
			$finish;
		end
	end

	function automatic logic [7:0] random_char();
		logic [7:0] c;
		do
			c = 8'($urandom_range(0, 255));
		while (c == CHAR_COLON);
		return c;
	endfunction

	// Two hex digits, high first, random letter case; noisy digits may be junk.
	function automatic void push_hex(input logic [7:0] b, input bit noisy);
		logic [3:0] n;
		for (int i = 1; i >= 0; i--) begin
			n = b[i*4 +: 4];
			if (noisy && $urandom_range(0, 11) == 0)
				rec_q.push_back(random_char());
			else if (n < 4'd10)
				rec_q.push_back(CHAR_ZERO + 8'(n));
			else
				rec_q.push_back(($urandom_range(0, 1) != 0 ? CHAR_LOW_A : CHAR_UP_A)
					+ 8'(n) - DIGIT_TEN);
		end
	endfunction

	// Length digits are always clean so a damaged record never ends the image.
	function automatic void build_record(input int len, input bit noisy);
		rec_q.push_back(CHAR_COLON);
		push_hex(8'(len), 1'b0);
		repeat (3)
			push_hex(8'($urandom), noisy);
		for (int i = 0; i < len; i++)
			push_hex(8'($urandom), noisy);
		push_hex(8'($urandom), noisy);
	endfunction

	task automatic send_char(input logic [7:0] c);
		if (!calm && (chars_sent % 128) >= 48 && $urandom_range(0, 5) == 0) begin
			chars.valid <= 1'b0;
			repeat ($urandom_range(1, 4))
				@(posedge clk);
		end
		chars.valid <= 1'b1;
		chars.ch <= c;
		@(posedge clk);
		while (!chars.ready)
			@(posedge clk);
		chars_sent++;
		if (chars_sent >= CALM_AFTER)
			calm = 1'b1;
	endtask

	task automatic send_record(input int count);
		for (int i = 0; i < count; i++)
			send_char(rec_q[i]);
		rec_q.delete();
		records_sent++;
	endtask

	// Receiver: random short stalls in alternating windows, one long hold-off.
	initial begin : receiver
		int  stall_left;
		int  rx_cycle;
		bit  held;
		stall_left = 0;
		rx_cycle = 0;
		held = 1'b0;
		image.ready = 1'b0;
		forever begin
			@(posedge clk);
			rx_cycle++;
			if (stall_left > 0) begin
				stall_left--;
				image.ready <= 1'b0;
			end else if (!held && rx_cycle == HOLD_START) begin
				held = 1'b1;
				stall_left = HOLD_CYCLES - 1;
				image.ready <= 1'b0;
			end else if (!calm && (rx_cycle % 128) >= 64 && $urandom_range(0, 4) == 0) begin
				stall_left = $urandom_range(0, 3);
				image.ready <= 1'b0;
			end else
				image.ready <= 1'b1;
		end
	end

	initial begin : stimulus
		int kind;
		int len;
		int drain;
		bit cut;
		chars.valid = 1'b0;
		chars.ch = 8'h00;
		calm = 1'b0;
		chars_sent = 0;
		records_sent = 0;
		cut = 1'b0;
		arst_n = 1'b0;
		repeat (5)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// stray bytes before any record start
		send_char(8'h00);
		send_char(8'hFF);
		// base record, length 0 leaves the base at zero and length 1 sets only its high byte
		first_len = $urandom_range(0, 2);
		build_record(first_len, 1'b0);
		send_record(rec_q.size());
		// full record cut off by a colon right after its first data byte
		build_record(16, 1'b0);
		send_record(11);

		while (chars_sent < CHAR_TARGET) begin
			kind = $urandom_range(0, 19);
			if (kind == 0 && chars_sent + LONG_ROOM < CHAR_TARGET)
				len = $urandom_range(16, 255);
			else if (kind <= 3)
				len = SKIP_LENGTH;
			else
				len = $urandom_range(16, 24);
			build_record(len, kind >= 4 && kind < 8);
			cut = (kind == 19);
			if (cut)
				send_record($urandom_range(1, rec_q.size() - 1));
			else
				send_record(rec_q.size());
			// junk between records only after a complete one
			if (!cut && $urandom_range(0, 3) == 0)
				repeat ($urandom_range(1, 3))
					send_char(random_char());
		end

		// closing record: zero length or a short data record
		end_len = $urandom_range(0, 15);
		if (end_len == SKIP_LENGTH)
			end_len = 0;
		build_record(end_len, 1'b0);
		send_record(rec_q.size());
		// anything past the end of the image must be ignored
		send_char(CHAR_COLON);
		repeat (8)
			send_char(random_char());
		chars.valid <= 1'b0;

		drain = 0;
		while (pending != 0 && drain < DRAIN_LIMIT) begin
			@(posedge clk);
			drain++;
		end
		repeat (10)
			@(posedge clk);

		$display("Run: %0d characters in %0d records, %0d image beats checked,",
			chars_sent, records_sent, bytes_checked);
		$display("base record of %0d bytes, closing record of %0d bytes, one long output hold.",
			first_len, end_len);
		if (pending != 0)
			$display("%0d expected image beats never arrived", pending);
		if (fail_count == 0 && pending == 0)
			$display("hex_record_data_extractor verification clean");
		else
			$display("hex_record_data_extractor verification failed");
		$finish;
	end

endmodule
